@@ rtl/rgb_to_hsv_range_mask_macros.svh @@
// -----------------------------------------------------------------------------
// rgb_to_hsv_range_mask_macros.svh
// Assertion macros used by the checker file rhm_checker.sv.
// -----------------------------------------------------------------------------
`ifndef RGB_TO_HSV_RANGE_MASK_MACROS_SVH
`define RGB_TO_HSV_RANGE_MASK_MACROS_SVH

// same-cycle implication, clocked on clk, held off during reset
`define RHM_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define RHM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/rhm_pkg.sv @@
// -----------------------------------------------------------------------------
// rhm_pkg
// Types and constants for the BGR to HSV range mask pipeline.
// -----------------------------------------------------------------------------
`default_nettype none

package rhm_pkg;

	localparam int HUE_NUM_W = 18;
	localparam int HUE_DEN_W = 9;
	localparam int SAT_NUM_W = 16;
	localparam int SAT_DEN_W = 8;
	localparam int Q_W       = 9;
	localparam int CELLS     = Q_W;

	localparam logic signed [19:0] HUE_DIFF_MUL  = 20'sd120;
	localparam logic signed [19:0] COEF_RED      = 20'sd1;
	localparam logic signed [19:0] COEF_RED_WRAP = 20'sd721;
	localparam logic signed [19:0] COEF_GREEN    = 20'sd241;
	localparam logic signed [19:0] COEF_BLUE     = 20'sd481;

	localparam logic [8:0] DEG_LAST = 9'd359;
	localparam logic [8:0] DEG_FULL = 9'd360;

	localparam logic [7:0] HUE_LOW_RST  = 8'd22;
	localparam logic [7:0] HUE_HIGH_RST = 8'd83;
	localparam logic [7:0] SAT_LOW_RST  = 8'd43;
	localparam logic [7:0] SAT_HIGH_RST = 8'd255;
	localparam logic [7:0] VAL_LOW_RST  = 8'd35;
	localparam logic [7:0] VAL_HIGH_RST = 8'd255;

	typedef enum logic [2:0] {
		REG_HUE_LOW  = 3'd0,
		REG_HUE_HIGH = 3'd1,
		REG_SAT_LOW  = 3'd2,
		REG_SAT_HIGH = 3'd3,
		REG_VAL_LOW  = 3'd4,
		REG_VAL_HIGH = 3'd5
	} cfg_idx_t;

	typedef enum logic [2:0] {
		SEC_RED   = 3'b001,
		SEC_GREEN = 3'b010,
		SEC_BLUE  = 3'b100
	} sec_t;

	typedef struct packed {
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
	} pixel_t;

	typedef struct packed {
		logic                 grey;
		logic [HUE_NUM_W-1:0] hue_rem;
		logic [HUE_DEN_W-1:0] hue_den;
		logic [Q_W-1:0]       hue_quo;
		logic [SAT_NUM_W-1:0] sat_rem;
		logic [SAT_DEN_W-1:0] sat_den;
		logic [Q_W-1:0]       sat_quo;
		logic [7:0]           value;
		pixel_t               pix;
	} item_t;

endpackage

`default_nettype wire

@@ rtl/rgb_to_hsv_range_mask.sv @@
// -----------------------------------------------------------------------------
// rgb_to_hsv_range_mask
// BGR pixel to HSV with an inclusive range mask. Takes one pixel per clock
// while in_stall is low and returns the pixels in order: two front stages
// find max, min and the dividends, a row of nine division cells settles one
// quotient bit of hue and saturation each, and a last stage wraps the hue,
// tests the bounds and registers the item. The row moves as a whole, so
// in_stall is raised only while a finished item is held by out_stall. Bound
// registers are written through the cfg channel, which is always ready;
// unknown indexes are dropped.
// -----------------------------------------------------------------------------
`default_nettype none

module rgb_to_hsv_range_mask import rhm_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] blue,
	input  logic [7:0] green,
	input  logic [7:0] red,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] hue,
	output logic [7:0] saturation,
	output logic [7:0] value,
	output logic       in_range,
	output logic [7:0] out_blue,
	output logic [7:0] out_green,
	output logic [7:0] out_red,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [2:0] cfg_index,
	input  logic [7:0] cfg_data
);

	logic       en;
	logic [7:0] hue_low_q, hue_high_q, sat_low_q, sat_high_q, val_low_q, val_high_q;

	logic       chain_v [CELLS+1];
	item_t      chain_d [CELLS+1];

	item_t      fin;
	logic [8:0] deg_w;
	logic [7:0] hue_w, sat_w;
	logic       check_w, inside_w, black_w;

	logic       vld_s12;

	assign en        = !(vld_s12 && out_stall);
	assign in_stall  = !en;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hue_low_q  <= HUE_LOW_RST;
			hue_high_q <= HUE_HIGH_RST;
			sat_low_q  <= SAT_LOW_RST;
			sat_high_q <= SAT_HIGH_RST;
			val_low_q  <= VAL_LOW_RST;
			val_high_q <= VAL_HIGH_RST;
		end else if (cfg_valid) begin
			unique case (cfg_idx_t'(cfg_index))
				REG_HUE_LOW:  hue_low_q  <= cfg_data;
				REG_HUE_HIGH: hue_high_q <= cfg_data;
				REG_SAT_LOW:  sat_low_q  <= cfg_data;
				REG_SAT_HIGH: sat_high_q <= cfg_data;
				REG_VAL_LOW:  val_low_q  <= cfg_data;
				REG_VAL_HIGH: val_high_q <= cfg_data;
				default: ;
			endcase
		end
	end

	rhm_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.vld_i  (in_valid && !in_stall),
		.blue   (blue),
		.green  (green),
		.red    (red),
		.vld_o  (chain_v[0]),
		.item_o (chain_d[0])
	);

	for (genvar j = 0; j < CELLS; j++) begin : g_cell
		rhm_cell #(
			.SHIFT (Q_W - 1 - j)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.vld_i  (chain_v[j]),
			.item_i (chain_d[j]),
			.vld_o  (chain_v[j+1]),
			.item_o (chain_d[j+1])
		);
	end

	always_comb begin
		fin = chain_d[CELLS];
		if (fin.grey) begin
			deg_w = '0;
		end else if (fin.hue_quo > DEG_LAST) begin
			deg_w = fin.hue_quo - DEG_FULL;
		end else begin
			deg_w = fin.hue_quo;
		end
		hue_w    = deg_w[8:1];
		sat_w    = (fin.value == 8'd0) ? 8'd0 : fin.sat_quo[7:0];
		check_w  = (hue_high_q > hue_low_q) && (sat_high_q > sat_low_q)
		           && (val_high_q > val_low_q);
		inside_w = (hue_w >= hue_low_q) && (hue_w <= hue_high_q)
		           && (sat_w >= sat_low_q) && (sat_w <= sat_high_q)
		           && (fin.value >= val_low_q) && (fin.value <= val_high_q);
		black_w  = check_w && !inside_w;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s12 <= 1'b0;
		end else if (en) begin
			vld_s12 <= chain_v[CELLS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hue        <= hue_w;
			saturation <= sat_w;
			value      <= fin.value;
			in_range   <= check_w && inside_w;
			out_blue   <= black_w ? 8'd0 : fin.pix.blue;
			out_green  <= black_w ? 8'd0 : fin.pix.green;
			out_red    <= black_w ? 8'd0 : fin.pix.red;
		end
	end

	assign out_valid = vld_s12;

endmodule

`default_nettype wire

@@ rtl/rhm_cell.sv @@
// -----------------------------------------------------------------------------
// rhm_cell
// One restoring-division cell: settles one quotient bit of hue and of
// saturation, then hands the item to the next cell.
// -----------------------------------------------------------------------------
`default_nettype none

module rhm_cell import rhm_pkg::*; #(
	parameter int unsigned SHIFT = 0
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  en,
	input  logic  vld_i,
	input  item_t item_i,
	output logic  vld_o,
	output item_t item_o
);

	localparam int HHW = HUE_NUM_W - int'(SHIFT);
	localparam int HCW = ((HHW > HUE_DEN_W) ? HHW : HUE_DEN_W) + 1;
	localparam int SHW = SAT_NUM_W - int'(SHIFT);
	localparam int SCW = ((SHW > SAT_DEN_W) ? SHW : SAT_DEN_W) + 1;

	logic [HCW-1:0] h_hi, h_den, h_diff;
	logic [SCW-1:0] s_hi, s_den, s_diff;
	logic           h_take, s_take;
	item_t          nxt;
	logic           vld_q;
	item_t          item_q;

	always_comb begin
		h_hi   = HCW'(item_i.hue_rem[HUE_NUM_W-1:SHIFT]);
		h_den  = HCW'(item_i.hue_den);
		h_take = (h_hi >= h_den);
		h_diff = h_hi - h_den;
		s_hi   = SCW'(item_i.sat_rem[SAT_NUM_W-1:SHIFT]);
		s_den  = SCW'(item_i.sat_den);
		s_take = (s_hi >= s_den);
		s_diff = s_hi - s_den;

		nxt = item_i;
		if (h_take) begin
			nxt.hue_rem[HUE_NUM_W-1:SHIFT] = h_diff[HHW-1:0];
		end
		if (s_take) begin
			nxt.sat_rem[SAT_NUM_W-1:SHIFT] = s_diff[SHW-1:0];
		end
		nxt.hue_quo = {item_i.hue_quo[Q_W-2:0], h_take};
		nxt.sat_quo = {item_i.sat_quo[Q_W-2:0], s_take};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= vld_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			item_q <= nxt;
		end
	end

	assign vld_o  = vld_q;
	assign item_o = item_q;

endmodule

`default_nettype wire

@@ rtl/rhm_front.sv @@
// -----------------------------------------------------------------------------
// rhm_front
// Max, min and sector of the pixel, then the hue and saturation dividends
// and divisors that feed the cell row.
// -----------------------------------------------------------------------------
`default_nettype none

module rhm_front import rhm_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       en,
	input  logic       vld_i,
	input  logic [7:0] blue,
	input  logic [7:0] green,
	input  logic [7:0] red,
	output logic       vld_o,
	output item_t      item_o
);

	sec_t        sec_w;
	logic [7:0]  mx_w, mn_w;
	logic signed [8:0] diff_w;

	logic        vld_s1;
	pixel_t      pix_s1;
	sec_t        sec_s1;
	logic [7:0]  mx_s1, delta_s1;
	logic signed [8:0] diff_s1;

	logic signed [19:0] diff_x, delta_x, coef, num_w;
	item_t       item_w;

	logic        vld_s2;
	item_t       item_s2;

	always_comb begin
		if (red >= green && red >= blue) begin
			sec_w  = SEC_RED;
			mx_w   = red;
			diff_w = signed'({1'b0, green}) - signed'({1'b0, blue});
		end else if (green >= blue) begin
			sec_w  = SEC_GREEN;
			mx_w   = green;
			diff_w = signed'({1'b0, blue}) - signed'({1'b0, red});
		end else begin
			sec_w  = SEC_BLUE;
			mx_w   = blue;
			diff_w = signed'({1'b0, red}) - signed'({1'b0, green});
		end
		mn_w = (red < green) ? red : green;
		if (blue < mn_w) begin
			mn_w = blue;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_i;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pix_s1   <= '{blue: blue, green: green, red: red};
			sec_s1   <= sec_w;
			mx_s1    <= mx_w;
			delta_s1 <= mx_w - mn_w;
			diff_s1  <= diff_w;
		end
	end

	// twice the hue times delta, plus delta; negative red sector wraps by 720 delta
	always_comb begin
		diff_x  = {{11{diff_s1[8]}}, diff_s1};
		delta_x = {12'd0, delta_s1};
		unique case (sec_s1)
			SEC_RED:   coef = diff_s1[8] ? COEF_RED_WRAP : COEF_RED;
			SEC_GREEN: coef = COEF_GREEN;
			SEC_BLUE:  coef = COEF_BLUE;
			default:   coef = COEF_RED;
		endcase
		num_w = diff_x * HUE_DIFF_MUL + delta_x * coef;

		item_w         = '0;
		item_w.grey    = (delta_s1 == 8'd0);
		item_w.hue_rem = num_w[HUE_NUM_W-1:0];
		item_w.hue_den = {delta_s1, 1'b0};
		item_w.sat_rem = {delta_s1, 8'd0} - {8'd0, delta_s1};
		item_w.sat_den = mx_s1;
		item_w.value   = mx_s1;
		item_w.pix     = pix_s1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			item_s2 <= item_w;
		end
	end

	assign vld_o  = vld_s2;
	assign item_o = item_s2;

endmodule

`default_nettype wire

@@ rtl/rhm_checker.sv @@
// -----------------------------------------------------------------------------
// rhm_checker
// Port-level checks on the range mask block, bound to the top level.
// -----------------------------------------------------------------------------
`default_nettype none

`include "rgb_to_hsv_range_mask_macros.svh"

module rhm_checker (
	input wire       clk,
	input wire       arst_n,
	input wire       in_stall,
	input wire       out_valid,
	input wire       out_stall,
	input wire [7:0] hue,
	input wire [7:0] saturation,
	input wire [7:0] value,
	input wire [7:0] out_red
);

	`RHM_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(hue) && $stable(saturation) && $stable(out_red), "held item changed")
	`RHM_ASSERT_NOW(a_back_press, out_valid && out_stall, in_stall, "input taken while output held")
	`RHM_ASSERT_NOW(a_hue_span, out_valid, hue <= 8'd179, "hue beyond 179")
	`RHM_ASSERT_NOW(a_black_sat, out_valid && value == 8'd0, saturation == 8'd0, "black pixel with saturation")
	`RHM_ASSERT_NOW(a_grey_hue, out_valid && saturation == 8'd0, hue == 8'd0, "grey pixel with hue")

endmodule

bind rgb_to_hsv_range_mask rhm_checker u_rhm_checker (.*);

`default_nettype wire

@@ tb/sv/tb_rgb_to_hsv_range_mask.sv @@
// -----------------------------------------------------------------------------
// tb_rgb_to_hsv_range_mask
// Self-checking bench for the BGR to HSV range mask. A clocked driver sends
// pixels from a queue, and an in-bench HSV model predicts each result from the
// bounds it holds. A clocked monitor checks every result field against the
// oldest prediction. Bound sets are changed between phases while the pipe is
// empty. Both sides idle at random, and the receiver makes long hold-offs.
// -----------------------------------------------------------------------------
`default_nettype none

module tb_rgb_to_hsv_range_mask;
	timeunit 1ns;
	timeprecision 1ps;

	import rhm_pkg::*;

	localparam logic [2:0] REG_SPARE_6 = 3'd6;
	localparam logic [2:0] REG_SPARE_7 = 3'd7;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int HOLD_CYCLES    = 60;
	localparam int FLUSH_CYCLES   = 16;
	localparam int REPORT_MAX     = 10;

	typedef struct packed {
		logic [7:0] hue;
		logic [7:0] saturation;
		logic [7:0] value;
		logic       in_range;
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
	} hsv_result_t;

	typedef struct packed {
		pixel_t      pix;
		hsv_result_t res;
	} awaited_t;

	logic       clk        = 1'b0;
	logic       arst_n     = 1'b0;
	logic       in_valid   = 1'b0;
	logic       in_stall;
	logic [7:0] blue       = 8'd0;
	logic [7:0] green      = 8'd0;
	logic [7:0] red        = 8'd0;
	logic       out_valid;
	logic       out_stall  = 1'b0;
	logic [7:0] hue;
	logic [7:0] saturation;
	logic [7:0] value;
	logic       in_range;
	logic [7:0] out_blue;
	logic [7:0] out_green;
	logic [7:0] out_red;
	logic       cfg_valid  = 1'b0;
	logic       cfg_ready;
	logic [2:0] cfg_index  = REG_HUE_LOW;
	logic [7:0] cfg_data   = 8'd0;

	logic [7:0] bound_regs [0:5];
	pixel_t     pixels_to_send [$];
	awaited_t   hsv_awaited [$];

	logic src_gaps = 1'b1;
	logic snk_gaps = 1'b1;
	int   items_sent      = 0;
	int   results_checked = 0;
	int   mismatches      = 0;
	int   flagged         = 0;
	int   blackened       = 0;
	int   cfg_writes      = 0;
	int   phases          = 0;
	int   hold_left       = 0;
	int   holds_done      = 0;
	int   quiet_cycles    = 0;

	rgb_to_hsv_range_mask u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.blue       (blue),
		.green      (green),
		.red        (red),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.hue        (hue),
		.saturation (saturation),
		.value      (value),
		.in_range   (in_range),
		.out_blue   (out_blue),
		.out_green  (out_green),
		.out_red    (out_red),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	always #5 clk = ~clk;

	// HSV conversion and bound test on the current bound set
	function automatic hsv_result_t hsv_mask_of(pixel_t px);
		int b, g, r, mx, mn, delta, num, deg, sat;
		logic test_on, in_bounds;
		hsv_result_t res;
		b = px.blue;
		g = px.green;
		r = px.red;
		mx = (b > g) ? b : g;
		mx = (mx > r) ? mx : r;
		mn = (b < g) ? b : g;
		mn = (mn < r) ? mn : r;
		delta = mx - mn;
		sat = (mx == 0) ? 0 : (255 * delta) / mx;
		if (delta == 0) begin
			deg = 0;
		end else begin
			if (r == mx)
				num = 60 * (g - b);
			else if (g == mx)
				num = 60 * (b - r) + 120 * delta;
			else
				num = 60 * (r - g) + 240 * delta;
			if (num < 0)
				num += 360 * delta;
			deg = (2 * num + delta) / (2 * delta);
			if (deg > 359)
				deg -= 360;
		end
		res.hue        = 8'(deg / 2);
		res.saturation = 8'(sat);
		res.value      = 8'(mx);
		test_on = bound_regs[REG_HUE_HIGH] > bound_regs[REG_HUE_LOW] &&
			bound_regs[REG_SAT_HIGH] > bound_regs[REG_SAT_LOW] &&
			bound_regs[REG_VAL_HIGH] > bound_regs[REG_VAL_LOW];
		in_bounds = res.hue >= bound_regs[REG_HUE_LOW] &&
			res.hue <= bound_regs[REG_HUE_HIGH] &&
			res.saturation >= bound_regs[REG_SAT_LOW] &&
			res.saturation <= bound_regs[REG_SAT_HIGH] &&
			res.value >= bound_regs[REG_VAL_LOW] && res.value <= bound_regs[REG_VAL_HIGH];
		res.in_range = test_on && in_bounds;
		res.blue  = (test_on && !in_bounds) ? 8'd0 : px.blue;
		res.green = (test_on && !in_bounds) ? 8'd0 : px.green;
		res.red   = (test_on && !in_bounds) ? 8'd0 : px.red;
		return res;
	endfunction

	// mostly uniform, with greys, ties, dark pixels and saturated channels mixed in
	function automatic pixel_t random_pixel();
		pixel_t px;
		int pick;
		logic [7:0] hi, lo;
		pick = $urandom_range(99);
		px.blue  = 8'($urandom_range(255));
		px.green = 8'($urandom_range(255));
		px.red   = 8'($urandom_range(255));
		if (pick >= 60 && pick < 68) begin
			px.green = px.blue;
			px.red   = px.blue;
		end else if (pick >= 68 && pick < 84) begin
			hi = 8'($urandom_range(255));
			lo = 8'($urandom_range(hi));
			case ($urandom_range(5))
				0: px = '{blue: hi, green: hi, red: lo};
				1: px = '{blue: hi, green: lo, red: hi};
				2: px = '{blue: lo, green: hi, red: hi};
				3: px = '{blue: lo, green: lo, red: hi};
				4: px = '{blue: lo, green: hi, red: lo};
				default: px = '{blue: hi, green: lo, red: lo};
			endcase
		end else if (pick >= 84 && pick < 94) begin
			px.blue  = 8'($urandom_range(15));
			px.green = 8'($urandom_range(15));
			px.red   = 8'($urandom_range(15));
		end else if (pick >= 94) begin
			px.red   = 8'd255;
			px.blue  = 8'($urandom_range(3));
			px.green = 8'($urandom_range(3));
		end
		return px;
	endfunction

	task automatic push_pixel(input logic [7:0] b, input logic [7:0] g, input logic [7:0] r);
		pixel_t px;
		px.blue  = b;
		px.green = g;
		px.red   = r;
		pixels_to_send.push_back(px);
	endtask

	task automatic wait_drained();
		while (pixels_to_send.size() != 0 || in_valid || hsv_awaited.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [7:0] data);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx <= REG_VAL_HIGH)
			bound_regs[idx] = data;
		cfg_writes++;
	endtask

	// new bound set once the pipe is empty, then a batch of random pixels
	task automatic run_phase(input logic [7:0] h_lo, input logic [7:0] h_hi,
			input logic [7:0] s_lo, input logic [7:0] s_hi,
			input logic [7:0] v_lo, input logic [7:0] v_hi, input int count);
		wait_drained();
		write_reg(REG_HUE_LOW, h_lo);
		write_reg(REG_HUE_HIGH, h_hi);
		write_reg(REG_SAT_LOW, s_lo);
		write_reg(REG_SAT_HIGH, s_hi);
		write_reg(REG_VAL_LOW, v_lo);
		write_reg(REG_VAL_HIGH, v_hi);
		@(negedge clk);
		repeat (count)
			pixels_to_send.push_back(random_pixel());
		phases++;
	endtask

	always @(posedge clk or negedge arst_n) begin : driver
		pixel_t px;
		if (!arst_n) begin
			in_valid <= 1'b0;
			blue     <= 8'd0;
			green    <= 8'd0;
			red      <= 8'd0;
		end else begin
			if (in_valid && !in_stall) begin
				px = {blue, green, red};
				hsv_awaited.push_back({px, hsv_mask_of(px)});
				items_sent++;
			end
			if (!in_valid || !in_stall) begin
				if (pixels_to_send.size() != 0 && !(src_gaps && $urandom_range(99) < 9)) begin
					px = pixels_to_send.pop_front();
					in_valid <= 1'b1;
					blue     <= px.blue;
					green    <= px.green;
					red      <= px.red;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin : monitor
		hsv_result_t seen;
		awaited_t want;
		logic differs;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				seen = {hue, saturation, value, in_range, out_blue, out_green, out_red};
				if (hsv_awaited.size() == 0) begin
					mismatches++;
					if (mismatches <= REPORT_MAX)
						$display("%0t: unexpected item h=%0d s=%0d v=%0d m=%0b bgr=%0d,%0d,%0d",
							$time, seen.hue, seen.saturation, seen.value, seen.in_range,
							seen.blue, seen.green, seen.red);
				end else begin
					want = hsv_awaited.pop_front();
					differs = seen.hue !== want.res.hue ||
						seen.saturation !== want.res.saturation ||
						seen.value !== want.res.value ||
						seen.in_range !== want.res.in_range ||
						seen.blue !== want.res.blue || seen.green !== want.res.green ||
						seen.red !== want.res.red;
					if (differs) begin
						mismatches++;
						if (mismatches <= REPORT_MAX)
							$display({"%0t: pixel bgr=%0d,%0d,%0d exp h=%0d s=%0d v=%0d m=%0b ",
								"bgr=%0d,%0d,%0d got h=%0d s=%0d v=%0d m=%0b bgr=%0d,%0d,%0d"},
								$time, want.pix.blue, want.pix.green, want.pix.red,
								want.res.hue, want.res.saturation, want.res.value,
								want.res.in_range, want.res.blue, want.res.green, want.res.red,
								seen.hue, seen.saturation, seen.value, seen.in_range,
								seen.blue, seen.green, seen.red);
					end
					if (want.res.in_range)
						flagged++;
					if (want.pix != '0 && want.res.blue == 8'd0 && want.res.green == 8'd0 &&
							want.res.red == 8'd0)
						blackened++;
				end
				results_checked++;
			end
			// long hold-offs so the pipe fills and backs up into the input
			if (hold_left != 0) begin
				out_stall <= 1'b1;
				hold_left <= hold_left - 1;
			end else if (holds_done < 2 && pixels_to_send.size() > 30 &&
					results_checked >= ((holds_done == 0) ? 100 : 700)) begin
				out_stall  <= 1'b1;
				hold_left  <= HOLD_CYCLES;
				holds_done <= holds_done + 1;
			end else begin
				out_stall <= snk_gaps && ($urandom_range(99) < 9);
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no handshake for %0d cycles, %0d items outstanding",
				$time, quiet_cycles, hsv_awaited.size());
			$display("tb_rgb_to_hsv_range_mask: FAIL");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		int h_lo, s_lo, v_lo;
		bound_regs[REG_HUE_LOW]  = HUE_LOW_RST;
		bound_regs[REG_HUE_HIGH] = HUE_HIGH_RST;
		bound_regs[REG_SAT_LOW]  = SAT_LOW_RST;
		bound_regs[REG_SAT_HIGH] = SAT_HIGH_RST;
		bound_regs[REG_VAL_LOW]  = VAL_LOW_RST;
		bound_regs[REG_VAL_HIGH] = VAL_HIGH_RST;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset bounds: black, white, greys, primaries, ties, hue wrap, in-range greens
		push_pixel(8'd0, 8'd0, 8'd0);
		push_pixel(8'd255, 8'd255, 8'd255);
		push_pixel(8'd128, 8'd128, 8'd128);
		push_pixel(8'd1, 8'd1, 8'd1);
		push_pixel(8'd0, 8'd0, 8'd255);
		push_pixel(8'd0, 8'd255, 8'd0);
		push_pixel(8'd255, 8'd0, 8'd0);
		push_pixel(8'd0, 8'd255, 8'd255);
		push_pixel(8'd255, 8'd255, 8'd0);
		push_pixel(8'd255, 8'd0, 8'd255);
		push_pixel(8'd1, 8'd0, 8'd255);
		push_pixel(8'd0, 8'd1, 8'd255);
		push_pixel(8'd254, 8'd255, 8'd255);
		push_pixel(8'd0, 8'd200, 8'd100);
		push_pixel(8'd50, 8'd180, 8'd60);
		push_pixel(8'd10, 8'd100, 8'd90);
		push_pixel(8'd0, 8'd0, 8'd1);
		push_pixel(8'd255, 8'd254, 8'd0);
		push_pixel(8'd128, 8'd0, 8'd127);
		push_pixel(8'd0, 8'd40, 8'd30);
		push_pixel(8'd170, 8'd85, 8'd85);
		repeat (150)
			pixels_to_send.push_back(random_pixel());
		phases++;

		// widest bounds, run with no idling on either side
		wait_drained();
		src_gaps = 1'b0;
		snk_gaps = 1'b0;
		run_phase(8'd0, 8'd180, 8'd0, 8'd255, 8'd0, 8'd255, 150);
		wait_drained();
		src_gaps = 1'b1;
		snk_gaps = 1'b1;

		// equal and inverted bounds switch the test off
		run_phase(8'd90, 8'd90, 8'd0, 8'd255, 8'd0, 8'd255, 60);
		run_phase(8'd0, 8'd180, 8'd200, 8'd100, 8'd0, 8'd255, 60);
		run_phase(8'd0, 8'd180, 8'd0, 8'd255, 8'd255, 8'd0, 40);
		// hue bounds past 180 are compared as written
		run_phase(8'd100, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 80);
		run_phase(8'd200, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 60);
		run_phase(8'd100, 8'd130, 8'd100, 8'd200, 8'd50, 8'd200, 80);
		run_phase(8'd0, 8'd1, 8'd0, 8'd1, 8'd254, 8'd255, 60);
		run_phase(8'd179, 8'd180, 8'd254, 8'd255, 8'd0, 8'd1, 40);
		repeat (4) begin
			h_lo = $urandom_range(170);
			s_lo = $urandom_range(240);
			v_lo = $urandom_range(240);
			run_phase(8'(h_lo), 8'($urandom_range(180, h_lo + 1)), 8'(s_lo),
				8'($urandom_range(255, s_lo + 1)), 8'(v_lo),
				8'($urandom_range(255, v_lo + 1)), 50);
		end
		run_phase(8'($urandom_range(255)), 8'($urandom_range(255)), 8'($urandom_range(255)),
			8'($urandom_range(255)), 8'($urandom_range(255)), 8'($urandom_range(255)), 40);

		// writes to unused indexes must leave the bounds alone
		run_phase(8'd22, 8'd83, 8'd43, 8'd255, 8'd35, 8'd255, 0);
		write_reg(REG_SPARE_6, 8'hFF);
		write_reg(REG_SPARE_7, 8'h00);
		@(negedge clk);
		repeat (60)
			pixels_to_send.push_back(random_pixel());

		wait_drained();
		repeat (FLUSH_CYCLES) @(posedge clk);
		mismatches += hsv_awaited.size();

		$display("Sent %0d pixels over %0d bound sets (%0d register writes), checked %0d items",
			items_sent, phases, cfg_writes, results_checked);
		$display("%0d items flagged in range, %0d blackened, %0d receiver hold-offs",
			flagged, blackened, holds_done);
		if (mismatches == 0)
			$display("tb_rgb_to_hsv_range_mask: PASS");
		else
			$display("tb_rgb_to_hsv_range_mask: FAIL");
		$finish;
	end

endmodule

`default_nettype wire
